[hdl/dq_pkg.sv]
`timescale 1ns / 1ps

package dq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_O_W = 5;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_LOOK       = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2
  } state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dq_cmd_t;

endpackage

[hdl/dq_in_if.sv]
`timescale 1ns / 1ps

interface dq_in_if
  import dq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

[hdl/dq_out_if.sv]
`timescale 1ns / 1ps

interface dq_out_if
  import dq_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;
  logic [COUNT_O_W-1:0]      item_count;
  logic                      is_empty;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, output front_value, output back_value, output item_count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input back_value, input item_count,
                  input is_empty, input status, output ready);
endinterface

[hdl/dq_ctrl.sv]
`timescale 1ns / 1ps

module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    out_ready_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  output dq_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: state_d = S_READ;
      S_READ: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    out_valid_d   = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: cmd_o.exec = 1'b1;
      S_READ: begin
        // load the output word once the previous one has gone
        if (slot_free) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> out_valid_q)
    else $error("output word not presented after load");

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == S_EXEC)
    else $error("accepted word not executed");
`endif

endmodule

[hdl/dq_datapath.sv]
`timescale 1ns / 1ps

module dq_datapath
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dq_cmd_t                   cmd_i,
  input  logic [ACTION_W-1:0]       action_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic signed [VALUE_W-1:0] front_value_o,
  output logic signed [VALUE_W-1:0] back_value_o,
  output logic [COUNT_O_W-1:0]      item_count_o,
  output logic                      is_empty_o,
  output logic [STATUS_W-1:0]       status_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  action_e               act_q;
  logic [DATA_WIDTH-1:0] val_q;
  status_e               stat_q, stat_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;

  logic [DATA_WIDTH-1:0] front_rd_q, back_rd_q;
  logic [CW-1:0]         count_out_q;
  status_e               stat_out_q;

  logic                  full, empty;
  logic [AW-1:0]         head_dec, head_inc, tail_idx, back_idx;
  logic [SW-1:0]         tail_sum, back_sum;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign head_dec = (head_q == '0) ? AW'(DEPTH - 1) : head_q - 1'b1;
  assign head_inc = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + 1'b1;

  // ring positions one past the back and at the back, one wrap at most
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign back_sum = tail_sum - 1'b1;
  always_comb begin
    logic [SW-1:0] t, b;
    t = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    b = (back_sum >= SW'(DEPTH)) ? back_sum - SW'(DEPTH) : back_sum;
    tail_idx = t[AW-1:0];
    back_idx = b[AW-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    stat_d  = STAT_OK;
    wr_en   = 1'b0;
    wr_addr = tail_idx;
    case (act_q)
      ACT_PUSH_FRONT: begin
        if (full) begin
          stat_d = STAT_FULL;
        end else begin
          head_d  = head_dec;
          count_d = count_q + 1'b1;
          wr_en   = 1'b1;
          wr_addr = head_dec;
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          stat_d = STAT_FULL;
        end else begin
          count_d = count_q + 1'b1;
          wr_en   = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          stat_d = STAT_EMPTY;
        end else begin
          head_d  = head_inc;
          count_d = count_q - 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (empty) stat_d = STAT_EMPTY;
        else       count_d = count_q - 1'b1;
      end
      default: begin
        if (empty) stat_d = STAT_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_e'(action_i);
      val_q <= DATA_WIDTH'($unsigned(value_i));
    end
    if (cmd_i.exec) stat_q <= stat_d;
    if (cmd_i.load) begin
      count_out_q <= count_q;
      stat_out_q  <= stat_q;
    end
  end

  // two registered read ports, one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) mem[wr_addr] <= val_q;
    if (cmd_i.load) begin
      front_rd_q <= mem[head_q];
      back_rd_q  <= mem[back_idx];
    end
  end

  assign is_empty_o    = (count_out_q == '0);
  assign front_value_o = is_empty_o ? '0 : VALUE_W'(front_rd_q);
  assign back_value_o  = is_empty_o ? '0 : VALUE_W'(back_rd_q);
  assign item_count_o  = COUNT_O_W'(count_out_q);
  assign status_o      = stat_out_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  a_push_back_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && act_q == ACT_PUSH_BACK && !full |=> count_q == $past(count_q) + 1'b1)
    else $error("push at back did not grow the count");

  a_pop_empty_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && (act_q == ACT_POP_FRONT || act_q == ACT_POP_BACK) && empty
    |=> $stable(head_q) && $stable(count_q))
    else $error("removal from empty queue moved the pointers");
`endif

endmodule

[hdl/double_ended_queue.sv]
`timescale 1ns / 1ps
// Bounded double-ended queue on a ring of DEPTH entries.
// req_i carries one word per operation: action (push front, push back,
// remove front, remove back, look) and value, used by the pushes only.
// rsp_o returns one word per operation: front and back entries after it
// (zero when empty), the entry count, an empty flag and a status
// (ok, empty on a failed removal or look, full on a rejected push).
// Timing: a word is taken in the idle state; the exec step then updates the
// head pointer and count and writes the ring; the read step then reads
// front and back through the two registered read ports straight into the
// output register, once that register is free. A new word is taken only
// after this three-step sequence has returned to idle.
// The output register holds a response while rsp_o.ready is low; the next
// word is still accepted and executed, and waits in the read step until
// the held response is taken.
// Reset clears head pointer, count and valid; ring contents stay undefined
// and never reach rsp_o before being written. No clearing pass is needed.

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    req_i,
  dq_out_if.source rsp_o
);

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .out_ready_i (rsp_o.ready),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (req_i.action),
    .value_i       (req_i.value),
    .front_value_o (rsp_o.front_value),
    .back_value_o  (rsp_o.back_value),
    .item_count_o  (rsp_o.item_count),
    .is_empty_o    (rsp_o.is_empty),
    .status_o      (rsp_o.status)
  );

endmodule

[bench/double_ended_queue_test.sv]
`timescale 1ns / 1ps

module double_ended_queue_test;
  import dq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEF;
  localparam int unsigned IDX_W      = $clog2(DEPTH_DEF);
  localparam int unsigned HOLD_LEN   = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned WORDS_PER_PHASE = 345;
  localparam int unsigned MAX_REPORTS = 10;

  // Action codes past look; the block treats them as a look
  localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0]   front;
    logic [VALUE_W-1:0]   back;
    logic [COUNT_O_W-1:0] count;
    logic                 empty;
    logic [STATUS_W-1:0]  status;
  } deque_view_t;

  typedef struct packed {
    logic        pinned;
    deque_view_t view;
  } view_note_t;

  typedef struct {
    logic [ACTION_W-1:0] act;
    logic [VALUE_W-1:0]  val;
    int unsigned         reps;
    logic                pinned;
    deque_view_t         view;
  } stim_row_t;

  typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_EVEN} burst_mix_e;

  logic clk_i;
  logic rst_ni;

  dq_in_if  req_if ();
  dq_out_if rsp_if ();

  double_ended_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow deque
  logic [VALUE_W-1:0]   ring_q [DEPTH];
  logic [IDX_W-1:0]     head_q = '0;
  logic [COUNT_O_W-1:0] count_q = '0;

  deque_view_t expected_views [$];
  view_note_t  row_notes [$];
  stim_row_t   dir_rows [$];

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_request;

  int unsigned words_sent;
  int unsigned views_checked;
  int unsigned mismatches;
  int unsigned full_rejects;
  int unsigned empty_refusals;
  int unsigned times_full;
  int unsigned times_emptied;
  int unsigned holds_done;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic apply_deque_op(input logic [ACTION_W-1:0] act,
                                input logic [VALUE_W-1:0] val,
                                output deque_view_t view);
    logic [IDX_W-1:0] slot;
    view = '0;
    view.status = STAT_OK;
    case (act) inside
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (count_q >= DEPTH) begin
          view.status = STAT_FULL;
          full_rejects++;
        end else begin
          if (act == ACT_PUSH_FRONT) begin
            head_q = head_q - 1'b1;
            slot   = head_q;
          end else begin
            slot = head_q + count_q[IDX_W-1:0];
          end
          ring_q[slot] = val;
          count_q++;
          if (count_q == DEPTH) times_full++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (count_q == 0) begin
          view.status = STAT_EMPTY;
          empty_refusals++;
        end else begin
          if (act == ACT_POP_FRONT) head_q = head_q + 1'b1;
          count_q--;
          if (count_q == 0) times_emptied++;
        end
      end
      default: begin
        if (count_q == 0) begin
          view.status = STAT_EMPTY;
          empty_refusals++;
        end
      end
    endcase
    view.count = count_q;
    view.empty = (count_q == 0);
    if (count_q != 0) begin
      slot = head_q + count_q[IDX_W-1:0] - 1'b1;
      view.front = ring_q[head_q];
      view.back  = ring_q[slot];
    end
  endtask

  task automatic report_view(input string what, input deque_view_t want,
                             input deque_view_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s at result %0d: want front %h back %h count %0d empty %0b status %0d",
               what, views_checked, want.front, want.back, want.count, want.empty,
               want.status);
      $display("    got front %h back %h count %0d empty %0b status %0d",
               seen.front, seen.back, seen.count, seen.empty, seen.status);
    end
  endtask

  // Check results first, then predict for the word taken at the same edge
  always @(posedge clk_i) begin
    deque_view_t seen;
    deque_view_t want;
    view_note_t  note;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        seen = '{rsp_if.front_value, rsp_if.back_value, rsp_if.item_count,
                 rsp_if.is_empty, rsp_if.status};
        if (expected_views.size() == 0) begin
          report_view("Unexpected result", '0, seen);
        end else begin
          want = expected_views.pop_front();
          if (seen.front !== want.front || seen.back !== want.back ||
              seen.count !== want.count || seen.empty !== want.empty ||
              seen.status !== want.status)
            report_view("Mismatch", want, seen);
        end
        views_checked++;
      end
      if (req_if.valid && req_if.ready) begin
        note = row_notes.pop_front();
        apply_deque_op(req_if.action, req_if.value, want);
        if (note.pinned) want = note.view;
        expected_views.push_back(want);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        holds_done++;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("No handshake for %0d cycles, %0d results still outstanding",
             STALL_LIMIT, expected_views.size());
    $display("Test completed with failures");
    $finish;
  end

  task automatic offer_word(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                            input logic pinned, input deque_view_t view);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    row_notes.push_back('{pinned, view});
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.value  <= val;
    do @(posedge clk_i); while (!req_if.ready);
    words_sent++;
  endtask

  function automatic logic [ACTION_W-1:0] pick_action(burst_mix_e mix);
    int unsigned r;
    int unsigned push_pct;
    int unsigned pop_pct;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  begin push_pct = 70; pop_pct = 15; end
      MIX_DRAIN: begin push_pct = 15; pop_pct = 70; end
      default:   begin push_pct = 40; pop_pct = 40; end
    endcase
    if (r < push_pct)
      return $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    if (r < push_pct + pop_pct)
      return $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
    if (r < 95)
      return ACT_LOOK;
    return ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    deque_view_t none;
    deque_view_t empty_view;
    deque_view_t full_view;
    burst_mix_e  mix;
    int unsigned burst;
    int unsigned words_left;
    int unsigned phase;

    none       = '0;
    empty_view = '{32'h0, 32'h0, 5'd0, 1'b1, STAT_EMPTY};
    full_view  = '{32'h5555_5555, 32'hAAAA_AAAA, 5'd16, 1'b0, STAT_FULL};

    rst_ni         = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = 1'b0;
    req_if.valid  <= 1'b0;
    req_if.action <= ACT_LOOK;
    req_if.value  <= '0;

    // Empty queue refusals, extremes, spare codes, then fill past the ring
    // wrap and push against a full queue
    dir_rows.push_back('{ACT_LOOK,       32'h0, 1, 1'b1, empty_view});
    dir_rows.push_back('{ACT_POP_FRONT,  32'h0, 1, 1'b1, empty_view});
    dir_rows.push_back('{ACT_POP_BACK,   32'h0, 1, 1'b1, empty_view});
    dir_rows.push_back('{ACT_SPARE_LAST, 32'h0, 1, 1'b1, empty_view});
    dir_rows.push_back('{ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1'b1,
                         '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, STAT_OK}});
    dir_rows.push_back('{ACT_PUSH_BACK,  32'h8000_0000, 1, 1'b1,
                         '{32'h7FFF_FFFF, 32'h8000_0000, 5'd2, 1'b0, STAT_OK}});
    dir_rows.push_back('{ACT_SPARE_FIRST, 32'hFFFF_FFFF, 1, 1'b1,
                         '{32'h7FFF_FFFF, 32'h8000_0000, 5'd2, 1'b0, STAT_OK}});
    dir_rows.push_back('{ACT_POP_FRONT,  32'h0, 1, 1'b1,
                         '{32'h8000_0000, 32'h8000_0000, 5'd1, 1'b0, STAT_OK}});
    dir_rows.push_back('{ACT_POP_BACK,   32'h0, 1, 1'b1,
                         '{32'h0, 32'h0, 5'd0, 1'b1, STAT_OK}});
    dir_rows.push_back('{ACT_PUSH_BACK,  32'hFFFF_FFFF, 1, 1'b0, none});
    dir_rows.push_back('{ACT_PUSH_FRONT, 32'h0000_0000, 1, 1'b0, none});
    dir_rows.push_back('{ACT_PUSH_BACK,  32'hAAAA_AAAA, 7, 1'b0, none});
    dir_rows.push_back('{ACT_PUSH_FRONT, 32'h5555_5555, 7, 1'b0, none});
    dir_rows.push_back('{ACT_PUSH_BACK,  32'h1234_5678, 1, 1'b1, full_view});
    dir_rows.push_back('{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b1, full_view});
    dir_rows.push_back('{ACT_LOOK,       32'h0, 1, 1'b0, none});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      repeat (dir_rows[i].reps)
        offer_word(dir_rows[i].act, dir_rows[i].val, dir_rows[i].pinned, dir_rows[i].view);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 46; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 46; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      // Keep offering words while the receiver holds off, so the input backs up
      if (phase == 0) hold_request = 1'b1;
      words_left = WORDS_PER_PHASE;
      while (words_left > 0) begin
        mix   = burst_mix_e'($urandom_range(MIX_EVEN));
        burst = $urandom_range(8, 40);
        while (burst > 0 && words_left > 0) begin
          offer_word(pick_action(mix), pick_value(), 1'b0, none);
          burst--;
          words_left--;
        end
      end
    end

    req_if.valid <= 1'b0;
    while (expected_views.size() != 0 || row_notes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words, checked %0d results; %0d refused as full, %0d as empty.",
             words_sent, views_checked, full_rejects, empty_refusals);
    $display("Queue filled %0d times and drained %0d times; receiver held off %0d time(s).",
             times_full, times_emptied, holds_done);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
hdl/dq_pkg.sv
hdl/dq_in_if.sv
hdl/dq_out_if.sv
hdl/dq_ctrl.sv
hdl/dq_datapath.sv
hdl/double_ended_queue.sv
bench/double_ended_queue_test.sv
